// File: hw/rtl/dfiir_pkg.sv
// Types, constants and the control program shared by the direct form I IIR filter.
package dfiir_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int NUM_COEF  = 3;
    localparam int NUM_TAPS  = NUM_COEF - 1;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int STEP_W    = 4;

    localparam logic [1:0] KIND_FILTER = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_SHIFT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_2 = 3'd5;

    localparam logic signed [DATA_W-1:0] COEF_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_FILT  = 4'd1;
    localparam step_t STEP_MAC1  = 4'd2;
    localparam step_t STEP_MAC2  = 4'd3;
    localparam step_t STEP_MAC3  = 4'd4;
    localparam step_t STEP_MAC4  = 4'd5;
    localparam step_t STEP_MAC5  = 4'd6;
    localparam step_t STEP_LOAD  = 4'd7;
    localparam step_t STEP_DIV   = 4'd8;
    localparam step_t STEP_WB    = 4'd9;
    localparam step_t STEP_DONE  = 4'd10;
    localparam step_t STEP_SET   = 4'd11;
    localparam step_t STEP_SHIFT = 4'd12;

    // Multiplier operand pair
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_B0_VAL,
        SRC_B1_X0,
        SRC_A1_Y0,
        SRC_B2_X1,
        SRC_A2_Y1
    } src_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        DIV_HOLD,
        DIV_LOAD,
        DIV_STEP
    } div_op_t;

    typedef enum logic [1:0] {
        HIST_HOLD,
        HIST_FILTER,
        HIST_SET,
        HIST_SHIFT
    } hist_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_LOOP
    } jmp_t;

    typedef struct packed {
        src_t     src;
        acc_op_t  acc;
        div_op_t  dv;
        hist_op_t hist;
        logic     ld_item;
        logic     done;
        jmp_t     jmp;
        step_t    target;
    } ctrl_t;

    typedef struct packed {
        ctrl_t word;
        logic  go;
    } seq_out_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     saturated;
        logic                     divide_error;
    } result_t;

    // Control store: one word per step
    function automatic ctrl_t ucode(step_t step);
        ctrl_t w;
        w = '0;
        case (step)
            STEP_IDLE:
            begin
                w.ld_item = 1'b1;
                w.jmp     = JMP_DISPATCH;
            end
            STEP_FILT:
            begin
                w.src = SRC_B0_VAL;
                w.acc = ACC_CLEAR;
            end
            STEP_MAC1:
            begin
                w.src = SRC_B1_X0;
                w.acc = ACC_ADD;
            end
            STEP_MAC2:
            begin
                w.src = SRC_A1_Y0;
                w.acc = ACC_ADD;
            end
            STEP_MAC3:
            begin
                w.src = SRC_B2_X1;
                w.acc = ACC_SUB;
            end
            STEP_MAC4:
            begin
                w.src = SRC_A2_Y1;
                w.acc = ACC_ADD;
            end
            STEP_MAC5:
            begin
                w.acc = ACC_SUB;
            end
            STEP_LOAD:
            begin
                w.dv = DIV_LOAD;
            end
            STEP_DIV:
            begin
                w.dv  = DIV_STEP;
                w.jmp = JMP_LOOP;
            end
            STEP_WB:
            begin
                w.hist = HIST_FILTER;
            end
            STEP_DONE:
            begin
                w.done   = 1'b1;
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
            STEP_SET:
            begin
                w.hist   = HIST_SET;
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_DONE;
            end
            STEP_SHIFT:
            begin
                w.hist   = HIST_SHIFT;
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_DONE;
            end
            default:
            begin
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/dfiir_useq.sv
// Step counter and branch logic that walks the filter's control program.
module dfiir_useq
    import dfiir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_kind,
    input  logic       out_busy,
    output logic       item_stall,
    output seq_out_t   seq
);

    step_t                pc_reg;
    step_t                pc_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    ctrl_t                word;
    logic                 go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= STEP_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        word     = ucode(pc_reg);
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        go       = 1'b1;

        // hold the result step until the output register frees up
        if (word.done)
        begin
            go = !out_busy;
        end

        case (word.jmp)
            JMP_NEXT:
            begin
                pc_next = step_t'(pc_reg + 1'b1);
            end
            JMP_ALWAYS:
            begin
                pc_next = word.target;
            end
            JMP_DISPATCH:
            begin
                go = item_valid;
                case (item_kind)
                    KIND_FILTER: pc_next = STEP_FILT;
                    KIND_SET:    pc_next = STEP_SET;
                    KIND_SHIFT:  pc_next = STEP_SHIFT;
                    default:     pc_next = STEP_DONE;
                endcase
            end
            JMP_LOOP:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    pc_next = step_t'(pc_reg + 1'b1);
                end
            end
            default:
            begin
                pc_next = STEP_IDLE;
            end
        endcase

        if (word.dv == DIV_LOAD)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
        end

        if (!go)
        begin
            pc_next = pc_reg;
        end

        item_stall = (word.jmp != JMP_DISPATCH);
        seq.word   = word;
        seq.go     = go;
    end

endmodule

// File: hw/rtl/dfiir_dpath.sv
// Coefficients, histories, multiply-accumulate and serial divider of the filter.
module dfiir_dpath
    import dfiir_pkg::*;
#(
    parameter int ORDER = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  seq_out_t                 seq,
    input  logic signed [DATA_W-1:0] item_sample,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output result_t                  result
);

    logic signed [DATA_W-1:0] num_coef_reg [NUM_COEF];
    logic signed [DATA_W-1:0] den_coef_reg [NUM_COEF];
    logic signed [DATA_W-1:0] in_hist_reg  [ORDER];
    logic signed [DATA_W-1:0] out_hist_reg [ORDER];
    logic signed [DATA_W-1:0] x_tap        [NUM_TAPS];
    logic signed [DATA_W-1:0] y_tap        [NUM_TAPS];

    logic signed [DATA_W-1:0] val_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        quo_reg;
    logic [DATA_W-1:0]        dvsr_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic                     sat_reg;
    logic                     derr_reg;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;

    logic                     acc_neg;
    logic                     acc_big;
    logic [ACC_W-1:0]         acc_mag;
    logic [DATA_W-1:0]        a0_mag;
    logic                     load_ovf;

    logic [DATA_W:0]          div_trial;
    logic [DATA_W:0]          div_diff;
    logic                     div_ge;

    logic signed [DATA_W-1:0] y_val;
    logic                     y_sat;

    logic signed [DATA_W-1:0] in_add   [ORDER];
    logic signed [DATA_W-1:0] out_add  [ORDER];
    logic                     add_sat;
    logic                     exec;

    assign exec = seq.go;

    // Taps beyond the history depth read as zero
    for (genvar g = 0; g < NUM_TAPS; g++)
    begin : g_tap
        if (g < ORDER)
        begin : g_on
            assign x_tap[g] = in_hist_reg[g];
            assign y_tap[g] = out_hist_reg[g];
        end
        else
        begin : g_off
            assign x_tap[g] = '0;
            assign y_tap[g] = '0;
        end
    end

    always_comb
    begin
        case (seq.word.src)
            SRC_B0_VAL:
            begin
                mul_a = num_coef_reg[0];
                mul_b = val_reg;
            end
            SRC_B1_X0:
            begin
                mul_a = num_coef_reg[1];
                mul_b = x_tap[0];
            end
            SRC_A1_Y0:
            begin
                mul_a = den_coef_reg[1];
                mul_b = y_tap[0];
            end
            SRC_B2_X1:
            begin
                mul_a = num_coef_reg[2];
                mul_b = x_tap[1];
            end
            SRC_A2_Y1:
            begin
                mul_a = den_coef_reg[2];
                mul_b = y_tap[1];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Divider setup: magnitudes, sign of the quotient and early overflow
    always_comb
    begin
        acc_neg  = acc_reg[ACC_W-1];
        acc_big  = !((&acc_reg[ACC_W-1:PROD_W-1]) || !(|acc_reg[ACC_W-1:PROD_W-1]));
        acc_mag  = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        a0_mag   = den_coef_reg[0][DATA_W-1] ? DATA_W'(-den_coef_reg[0])
                                             : DATA_W'(den_coef_reg[0]);
        // quotient reaches 2^32 when the high half is not below the divisor
        load_ovf = acc_big || (acc_mag[PROD_W-1:DATA_W] >= a0_mag);
    end

    always_comb
    begin
        div_trial = {rem_reg, quo_reg[DATA_W-1]};
        div_diff  = div_trial - {1'b0, dvsr_reg};
        div_ge    = (div_trial >= {1'b0, dvsr_reg});
    end

    // Sign and clamp the quotient; zero on a divide error
    always_comb
    begin
        y_val = '0;
        y_sat = 1'b0;
        if (derr_reg)
        begin
            y_val = '0;
        end
        else if (ovf_reg)
        begin
            y_sat = 1'b1;
            y_val = neg_reg ? DATA_MIN : DATA_MAX;
        end
        else if (neg_reg)
        begin
            if (quo_reg > DATA_W'(DATA_MIN))
            begin
                y_sat = 1'b1;
                y_val = DATA_MIN;
            end
            else
            begin
                y_val = DATA_W'(-quo_reg);
            end
        end
        else if (quo_reg[DATA_W-1])
        begin
            y_sat = 1'b1;
            y_val = DATA_MAX;
        end
        else
        begin
            y_val = quo_reg;
        end
    end

    function automatic logic [DATA_W:0] clamp_add(logic signed [DATA_W-1:0] h,
                                                  logic signed [DATA_W-1:0] v);
        logic [DATA_W:0] s;
        s = {h[DATA_W-1], h} + {v[DATA_W-1], v};
        if (s[DATA_W] != s[DATA_W-1])
        begin
            return {1'b1, (s[DATA_W] ? DATA_MIN : DATA_MAX)};
        end
        return {1'b0, s[DATA_W-1:0]};
    endfunction

    always_comb
    begin
        logic [DATA_W:0] r;
        add_sat = 1'b0;
        for (int i = 0; i < ORDER; i++)
        begin
            r          = clamp_add(in_hist_reg[i], val_reg);
            in_add[i]  = r[DATA_W-1:0];
            add_sat    = add_sat | r[DATA_W];
            r          = clamp_add(out_hist_reg[i], val_reg);
            out_add[i] = r[DATA_W-1:0];
            add_sat    = add_sat | r[DATA_W];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_coef_reg[0] <= COEF_ONE;
            num_coef_reg[1] <= '0;
            num_coef_reg[2] <= '0;
            den_coef_reg[0] <= COEF_ONE;
            den_coef_reg[1] <= '0;
            den_coef_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_COEF_0: num_coef_reg[0] <= cfg_data;
                REG_NUM_COEF_1: num_coef_reg[1] <= cfg_data;
                REG_NUM_COEF_2: num_coef_reg[2] <= cfg_data;
                REG_DEN_COEF_0: den_coef_reg[0] <= cfg_data;
                REG_DEN_COEF_1: den_coef_reg[1] <= cfg_data;
                REG_DEN_COEF_2: den_coef_reg[2] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Histories and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
            sat_reg  <= 1'b0;
            derr_reg <= 1'b0;
        end
        else if (exec)
        begin
            if (seq.word.ld_item)
            begin
                sat_reg  <= 1'b0;
                derr_reg <= 1'b0;
            end
            if (seq.word.dv == DIV_LOAD)
            begin
                derr_reg <= (den_coef_reg[0] == '0);
            end
            case (seq.word.hist)
                HIST_FILTER:
                begin
                    for (int i = ORDER - 1; i > 0; i--)
                    begin
                        in_hist_reg[i]  <= in_hist_reg[i-1];
                        out_hist_reg[i] <= out_hist_reg[i-1];
                    end
                    in_hist_reg[0]  <= val_reg;
                    out_hist_reg[0] <= y_val;
                    sat_reg         <= y_sat;
                end
                HIST_SET:
                begin
                    for (int i = 0; i < ORDER; i++)
                    begin
                        in_hist_reg[i]  <= val_reg;
                        out_hist_reg[i] <= val_reg;
                    end
                end
                HIST_SHIFT:
                begin
                    for (int i = 0; i < ORDER; i++)
                    begin
                        in_hist_reg[i]  <= in_add[i];
                        out_hist_reg[i] <= out_add[i];
                    end
                    sat_reg <= add_sat;
                end
                default: ;
            endcase
        end
    end

    // Arithmetic working registers
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            if (seq.word.ld_item)
            begin
                val_reg <= item_sample;
            end
            prod_reg <= prod_next;
            case (seq.word.acc)
                ACC_CLEAR: acc_reg <= '0;
                ACC_ADD:   acc_reg <= acc_reg + prod_ext;
                ACC_SUB:   acc_reg <= acc_reg - prod_ext;
                default:   ;
            endcase
            case (seq.word.dv)
                DIV_LOAD:
                begin
                    rem_reg  <= acc_mag[PROD_W-1:DATA_W];
                    quo_reg  <= acc_mag[DATA_W-1:0];
                    dvsr_reg <= a0_mag;
                    neg_reg  <= acc_neg ^ den_coef_reg[0][DATA_W-1];
                    ovf_reg  <= load_ovf;
                end
                DIV_STEP:
                begin
                    // one quotient bit per step
                    rem_reg <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
                    quo_reg <= {quo_reg[DATA_W-2:0], div_ge};
                end
                default: ;
            endcase
        end
    end

    assign result.filtered     = out_hist_reg[0];
    assign result.saturated    = sat_reg;
    assign result.divide_error = derr_reg;

endmodule

// File: hw/rtl/direct_form_iir_filter_top.sv
// Direct form I IIR filter top level: sequencer, datapath and result register.
//
// Second-order direct form I IIR filter on signed Q16.16 samples, run by a
// small control program over one shared 32x32 multiplier and a bit-serial
// divider. For a filter item, five products are accumulated exactly, then
// the sum is divided by a0 one quotient bit per cycle, and the result is
// loaded into the output register. The next item is accepted the cycle
// after a result is loaded, while that result may still wait on the output.
// Coefficient writes go straight to the registers; the user must make them
// only while the block idles, as the block itself does not enforce this.
module direct_form_iir_filter_top
    import dfiir_pkg::*;
#(
    parameter int ORDER = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    seq_out_t seq;
    result_t  dp_result;
    result_t  result_reg;
    logic     result_valid_reg;
    logic     out_busy;

    assign out_busy = result_valid_reg && result_stall;

    dfiir_useq u_useq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .out_busy   (out_busy),
        .item_stall (item_stall),
        .seq        (seq)
    );

    dfiir_dpath #(
        .ORDER (ORDER)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .seq         (seq),
        .item_sample (item.sample),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (seq.go && seq.word.done)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.go && seq.word.done)
        begin
            result_reg <= dp_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
